/* rtl/scpj_pkg.sv */
// Shared types, constants and arithmetic helpers of the subcarrier phase pi-jump remover.
package scpj_pkg;

  // Block dimensions.
  localparam int NUM_ANTENNAS  = 4;
  localparam int HISTORY_DEPTH = 4;
  localparam int SUBCARRIERS   = 64;
  localparam int MAX_ANT       = 4;
  localparam int IDX_W         = $clog2(SUBCARRIERS);

  // Datapath widths: phases are Q4.12, differences are formed at 18 bits.
  localparam int PHASE_W = 16;
  localparam int DIFF_W  = 18;
  localparam int MAG_W   = 17;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  typedef logic signed [PHASE_W-1:0] phase_t;
  typedef logic [MAG_W-1:0]          mag_t;

  // Fixed-point constants.
  localparam phase_t                    PI_PHASE    = 16'sd12868;
  localparam logic signed [DIFF_W-1:0] PI_Q        = 18'sd12868;
  localparam mag_t                      MAG_LIMIT_Q = 17'd7373;
  localparam logic signed [DIFF_W-1:0] SAT_MAX     = 18'sd32767;
  localparam logic signed [DIFF_W-1:0] SAT_MIN     = -18'sd32768;

  // Subcarrier index landmarks.
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_MID   = IDX_W'(32);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(58);
  localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(SUBCARRIERS - 1);

  // Item classes decided in the front stage.
  localparam logic [1:0] CLS_BYPASS = 2'd0;
  localparam logic [1:0] CLS_NULL   = 2'd1;
  localparam logic [1:0] CLS_FIRST  = 2'd2;
  localparam logic [1:0] CLS_TRACK  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  // One classified item on its way from the front to the back stage.
  typedef struct packed {
    logic [1:0]                 cls;
    phase_t [MAX_ANT-1:0]       x;
  } item_t;

  // Queue status seen by the front and back stages and the checks.
  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_status_t;

  // Absolute difference of two phases, exact in 17 bits.
  function automatic mag_t abs_diff(phase_t a, phase_t b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({{2{a[PHASE_W-1]}}, a}) - $signed({{2{b[PHASE_W-1]}}, b});
    abs_diff = d[DIFF_W-1] ? mag_t'(-d) : mag_t'(d);
  endfunction

  // Magnitude of one phase, exact in 17 bits.
  function automatic mag_t abs_phase(phase_t x);
    mag_t m;
    m = {x[PHASE_W-1], x};
    abs_phase = x[PHASE_W-1] ? -m : m;
  endfunction

  // Shift by pi down (down = 1) or up, saturated to 16 bits.
  function automatic phase_t shift_pi(phase_t x, logic down);
    logic signed [DIFF_W-1:0] s;
    s = down ? ($signed({{2{x[PHASE_W-1]}}, x}) - PI_Q)
             : ($signed({{2{x[PHASE_W-1]}}, x}) + PI_Q);
    if (s > SAT_MAX) begin
      shift_pi = 16'sh7fff;
    end else if (s < SAT_MIN) begin
      shift_pi = 16'sh8000;
    end else begin
      shift_pi = s[PHASE_W-1:0];
    end
  endfunction

endpackage

/* rtl/scpj_ifs.sv */
// Channel interfaces: antenna phases in, corrected phases and null flag out.
interface scpj_in_if;
  logic             valid;
  logic             ready;
  scpj_pkg::phase_t phase_ant0;
  scpj_pkg::phase_t phase_ant1;
  scpj_pkg::phase_t phase_ant2;
  scpj_pkg::phase_t phase_ant3;

  modport source (output valid, output phase_ant0, output phase_ant1,
                  output phase_ant2, output phase_ant3, input ready);
  modport sink   (input valid, input phase_ant0, input phase_ant1,
                  input phase_ant2, input phase_ant3, output ready);
endinterface

interface scpj_out_if;
  logic             valid;
  logic             ready;
  scpj_pkg::phase_t fixed_ant0;
  scpj_pkg::phase_t fixed_ant1;
  scpj_pkg::phase_t fixed_ant2;
  scpj_pkg::phase_t fixed_ant3;
  logic             null_nonzero;

  modport source (output valid, output fixed_ant0, output fixed_ant1,
                  output fixed_ant2, output fixed_ant3, output null_nonzero,
                  input ready);
  modport sink   (input valid, input fixed_ant0, input fixed_ant1,
                  input fixed_ant2, input fixed_ant3, input null_nonzero,
                  output ready);
endinterface

/* rtl/scpj_front.sv */
// Front stage: accepts items, tracks the subcarrier index and classifies each item.
module scpj_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enable,
  scpj_in_if.sink                       in_ch,
  input  scpj_pkg::q_status_t           q_stat,
  output logic                          push,
  output scpj_pkg::item_t               push_item,
  output logic [scpj_pkg::IDX_W-1:0]    index
);
  import scpj_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [1:0]       cls;

  // Accept whenever the queue has room.
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;
  assign index       = idx_r;

  // Subcarrier counter, wrapping after the last subcarrier.
  always_comb begin
    idx_nxt = idx_r;
    if (push) begin
      idx_nxt = (idx_r == IDX_WRAP) ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // When enabled, classify by index: null and guard carriers, the first data carrier, the rest; else bypass.
  always_comb begin
    if (!enable) begin
      cls = CLS_BYPASS;
    end else if (idx_r < IDX_FIRST || idx_r == IDX_MID || idx_r > IDX_LAST) begin
      cls = CLS_NULL;
    end else if (idx_r == IDX_FIRST) begin
      cls = CLS_FIRST;
    end else begin
      cls = CLS_TRACK;
    end
  end

  // Pack the item for the queue.
  always_comb begin
    push_item.cls  = cls;
    push_item.x[0] = in_ch.phase_ant0;
    push_item.x[1] = in_ch.phase_ant1;
    push_item.x[2] = in_ch.phase_ant2;
    push_item.x[3] = in_ch.phase_ant3;
  end

endmodule

/* rtl/scpj_queue.sv */
// Two-entry queue that decouples the front stage from the back stage.
module scpj_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  scpj_pkg::item_t      push_item,
  input  logic                 pop,
  output scpj_pkg::item_t      pop_item,
  output scpj_pkg::q_status_t  q_stat
);
  import scpj_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign q_stat.count = count_r;
  assign pop_item     = mem_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/scpj_back.sv */
// Back stage: history search, pi correction, history update and the output register.
module scpj_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scpj_pkg::mag_t       tol,
  input  scpj_pkg::q_status_t  q_stat,
  input  scpj_pkg::item_t      pop_item,
  output logic                 pop,
  scpj_out_if.source           out_ch
);
  import scpj_pkg::*;

  phase_t hist_r   [NUM_ANTENNAS][HISTORY_DEPTH];
  phase_t hist_nxt [NUM_ANTENNAS][HISTORY_DEPTH];
  phase_t x        [MAX_ANT];
  phase_t y        [MAX_ANT];
  logic   flag;
  phase_t fixed_r  [MAX_ANT];
  logic   flag_r;
  logic   out_valid_r;

  // Take the next item when the output register is free or being emptied.
  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  // Correction of one item.
  always_comb begin
    logic   found;
    phase_t h;
    flag  = 1'b0;
    found = 1'b0;
    h     = '0;
    for (int a = 0; a < MAX_ANT; a++) begin
      x[a] = $signed(pop_item.x[a]);
      y[a] = '0;
    end
    for (int a = 0; a < NUM_ANTENNAS; a++) begin
      for (int l = 0; l < HISTORY_DEPTH; l++) begin
        hist_nxt[a][l] = hist_r[a][l];
      end
    end
    case (pop_item.cls)
      CLS_NULL: begin
        for (int a = 0; a < NUM_ANTENNAS; a++) begin
          y[a] = x[a];
          if (x[a] != '0) begin
            flag = 1'b1;
          end
        end
      end
      CLS_FIRST: begin
        // Antenna 0 against the magnitude limit, the others against antenna 0.
        y[0] = (abs_phase(x[0]) >= MAG_LIMIT_Q) ? shift_pi(x[0], x[0] > 16'sd0) : x[0];
        for (int a = 1; a < NUM_ANTENNAS; a++) begin
          y[a] = (abs_diff(x[a], x[0]) > tol) ? shift_pi(x[a], x[a] > x[0]) : x[a];
        end
        for (int a = 0; a < NUM_ANTENNAS; a++) begin
          for (int l = 0; l < HISTORY_DEPTH; l++) begin
            hist_nxt[a][l] = y[a];
          end
        end
      end
      CLS_TRACK: begin
        // Newest entry beyond the tolerance wins; oldest is scanned first.
        for (int a = 0; a < NUM_ANTENNAS; a++) begin
          found = 1'b0;
          h     = '0;
          for (int l = 0; l < HISTORY_DEPTH; l++) begin
            if (abs_diff(x[a], hist_r[a][l]) > tol) begin
              found = 1'b1;
              h     = hist_r[a][l];
            end
          end
          y[a] = found ? shift_pi(x[a], x[a] >= h) : x[a];
          for (int l = 0; l < HISTORY_DEPTH - 1; l++) begin
            hist_nxt[a][l] = hist_r[a][l+1];
          end
          hist_nxt[a][HISTORY_DEPTH-1] = y[a];
        end
      end
      default: begin
        for (int a = 0; a < NUM_ANTENNAS; a++) begin
          y[a] = x[a];
        end
      end
    endcase
  end

  // Phase history, updated only when an item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_ANTENNAS; a++) begin
        for (int l = 0; l < HISTORY_DEPTH; l++) begin
          hist_r[a][l] <= '0;
        end
      end
    end else if (pop) begin
      hist_r <= hist_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      fixed_r <= y;
      flag_r  <= flag;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.fixed_ant0   = fixed_r[0];
  assign out_ch.fixed_ant1   = fixed_r[1];
  assign out_ch.fixed_ant2   = fixed_r[2];
  assign out_ch.fixed_ant3   = fixed_r[3];
  assign out_ch.null_nonzero = flag_r;

endmodule

/* rtl/subcarrier_phase_pi_jump_remover.sv */
// Top level of the subcarrier phase pi-jump remover with its register port.
// The block takes one item per clock cycle, sustained, while the output is ready,
// and delivers its result through the queue and the output register: the front stage
// classifies the item by subcarrier index into a two-entry queue, and the back stage
// searches the four-entry phase history of each antenna, applies the pi correction and
// updates the history as it takes the item. Stalls on either side are absorbed by the
// queue and the output register. The history resets to zero at once; there is no
// clearing pass. Registers: enable at byte address 0 (reset 1) and the jump offset
// at byte address 4 (reset 0); both are to be written only while the block is idle.
module subcarrier_phase_pi_jump_remover (
  input  logic                          clk,
  input  logic                          rst_n,
  scpj_in_if.sink                       in_ch,
  scpj_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scpj_pkg::ADDR_W-1:0]   paddr,
  input  logic [scpj_pkg::DATA_W-1:0]   pwdata,
  output logic [scpj_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import scpj_pkg::*;

  logic             enable_r;
  phase_t           jump_offset_r;
  logic             reg_sel;
  logic             wr_en;
  mag_t             tol;
  q_status_t        q_stat;
  logic             q_push;
  logic             q_pop;
  item_t            push_item;
  item_t            pop_item;
  logic [IDX_W-1:0] index;

  // Register port: writes complete in the access cycle, no wait states.
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b1;
      jump_offset_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ENABLE: enable_r      <= pwdata[0];
        REG_OFFSET: jump_offset_r <= pwdata[PHASE_W-1:0];
        default:    enable_r      <= enable_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, enable_r};
      REG_OFFSET: prdata = {{(DATA_W-PHASE_W){jump_offset_r[PHASE_W-1]}},
                            jump_offset_r};
      default:    prdata = '0;
    endcase
  end

  // Jump tolerance: distance between pi and the jump offset.
  assign tol = abs_diff(PI_PHASE, jump_offset_r);

  scpj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable_r),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_item (push_item),
    .index     (index)
  );

  scpj_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  scpj_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tol      (tol),
    .q_stat   (q_stat),
    .pop_item (pop_item),
    .pop      (q_pop),
    .out_ch   (out_ch)
  );

  // The front stage never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("item pushed into a full queue");

  // The queue fill count follows pushes and pops.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (q_stat.count ==
      $past(q_stat.count) + {1'b0, $past(q_push)} - {1'b0, $past(q_pop)}))
    else $error("queue fill count out of step with pushes and pops");

  // The subcarrier index advances by one on every accepted item short of the wrap.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && index != IDX_WRAP) |=> (index == $past(index) + IDX_W'(1)))
    else $error("subcarrier index did not advance");

endmodule
